// ===== design/htb_pkg.sv =====
`timescale 1ns / 1ps

package htb_pkg;

    // Result kinds
    localparam logic [2:0] KIND_DATA     = 3'd0;
    localparam logic [2:0] KIND_OK       = 3'd1;
    localparam logic [2:0] KIND_MISMATCH = 3'd2;
    localparam logic [2:0] KIND_NO_CKSUM = 3'd3;
    localparam logic [2:0] KIND_MIDLINE  = 3'd4;

    // One classified character
    typedef struct packed {
        logic       eof;
        logic       is_lf;
        logic       is_hex;
        logic [3:0] nibble;
    } t_token;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  data_byte;
        logic [15:0] computed_sum;
        logic [15:0] received_sum;
    } t_result;

    localparam int TOKEN_W  = $bits(t_token);
    localparam int RESULT_W = $bits(t_result);

endpackage

// ===== design/htb_fifo.sv =====
`timescale 1ns / 1ps

module htb_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr, n_wr;
    logic [AW-1:0]    r_rd, n_rd;
    logic [CW-1:0]    r_count, n_count;
    logic             push_ok;
    logic             pop_ok;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign push_ok = i_push && !o_full;
    assign pop_ok  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd];

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count + CW'(push_ok) - CW'(pop_ok);
        if (push_ok) begin
            n_wr = (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (pop_ok) begin
            n_rd = (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

// ===== design/htb_front.sv =====
`timescale 1ns / 1ps

module htb_front
    import htb_pkg::*;
(
    input  logic [7:0] i_character,
    input  logic       i_end_of_file,
    output t_token     o_token
);

    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_F = 8'h46;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_F = 8'h66;
    localparam logic [7:0] TEN        = 8'd10;

    logic is_digit;
    logic is_upper;
    logic is_lower;

    assign is_digit = (i_character >= CH_ZERO) && (i_character <= CH_NINE);
    assign is_upper = (i_character >= CH_UPPER_A) && (i_character <= CH_UPPER_F);
    assign is_lower = (i_character >= CH_LOWER_A) && (i_character <= CH_LOWER_F);

    always_comb begin
        o_token.eof    = i_end_of_file;
        o_token.is_lf  = (i_character == CH_NEWLINE);
        o_token.is_hex = is_digit || is_upper || is_lower;
        // anything that is not a letter digit falls back to (c - '0') mod 16
        if (is_upper) begin
            o_token.nibble = 4'(i_character - CH_UPPER_A + TEN);
        end else if (is_lower) begin
            o_token.nibble = 4'(i_character - CH_LOWER_A + TEN);
        end else begin
            o_token.nibble = 4'(i_character - CH_ZERO);
        end
    end

endmodule

// ===== design/htb_back.sv =====
`timescale 1ns / 1ps

module htb_back
    import htb_pkg::*;
#(
    parameter int SUM_WIDTH = 32
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_token  i_token,
    input  logic    i_tok_empty,
    output logic    o_tok_pop,
    input  logic    i_res_full,
    output logic    o_res_push,
    output t_result o_result
);

    typedef enum logic [2:0] {
        PH_HIGH = 3'b001,
        PH_LOW  = 3'b010,
        PH_DONE = 3'b100
    } t_phase;

    typedef enum logic [2:0] {
        CK_DATA = 3'b001,
        CK_HIGH = 3'b010,
        CK_LOW  = 3'b100
    } t_ck_mode;

    t_phase               r_phase, n_phase;
    t_ck_mode             r_ck, n_ck;
    logic [3:0]           r_high_nibble, n_high_nibble;
    logic                 r_col_odd, n_col_odd;
    logic                 r_line_data, n_line_data;
    logic [SUM_WIDTH-1:0] r_acc, n_acc;
    logic [7:0]           r_ck_high, n_ck_high;

    logic [7:0]           byte_val;
    logic [15:0]          folded;
    logic [15:0]          recv;

    assign o_tok_pop = !i_tok_empty && !i_res_full;
    assign byte_val  = {r_high_nibble, i_token.nibble};
    assign folded    = 16'(r_acc) + 16'(r_acc >> 16);
    assign recv      = {r_ck_high, byte_val};

    always_comb begin
        n_phase       = r_phase;
        n_ck          = r_ck;
        n_high_nibble = r_high_nibble;
        n_col_odd     = r_col_odd;
        n_line_data   = r_line_data;
        n_acc         = r_acc;
        n_ck_high     = r_ck_high;
        o_res_push    = 1'b0;
        o_result      = '0;
        if (o_tok_pop && (r_phase == PH_HIGH || r_phase == PH_LOW)) begin
            if (i_token.eof) begin
                n_phase = PH_DONE;
                if (r_line_data) begin
                    o_res_push    = 1'b1;
                    o_result.kind = KIND_MIDLINE;
                end else if (r_ck != CK_LOW) begin
                    o_res_push    = 1'b1;
                    o_result.kind = KIND_NO_CKSUM;
                end
            end else if (r_phase == PH_HIGH) begin
                if (i_token.is_lf) begin
                    // an empty line arms checksum capture, even a second time
                    if (!r_line_data) begin
                        n_ck = CK_HIGH;
                    end
                    n_col_odd   = 1'b0;
                    n_line_data = 1'b0;
                end else if (i_token.is_hex) begin
                    n_high_nibble = i_token.nibble;
                    n_phase       = PH_LOW;
                end
            end else begin
                n_phase = PH_HIGH;
                case (r_ck)
                    CK_HIGH: begin
                        n_ck_high = byte_val;
                        n_ck      = CK_LOW;
                    end
                    CK_LOW: begin
                        n_phase               = PH_DONE;
                        o_res_push            = 1'b1;
                        o_result.kind         = (folded == recv) ? KIND_OK : KIND_MISMATCH;
                        o_result.computed_sum = folded;
                        o_result.received_sum = recv;
                    end
                    default: begin
                        n_acc = r_acc + (r_col_odd ? SUM_WIDTH'(byte_val)
                                                   : SUM_WIDTH'({byte_val, 8'h00}));
                        n_col_odd          = !r_col_odd;
                        n_line_data        = 1'b1;
                        o_res_push         = 1'b1;
                        o_result.kind      = KIND_DATA;
                        o_result.data_byte = byte_val;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_HIGH;
            r_ck          <= CK_DATA;
            r_high_nibble <= '0;
            r_col_odd     <= 1'b0;
            r_line_data   <= 1'b0;
            r_acc         <= '0;
            r_ck_high     <= '0;
        end else begin
            r_phase       <= n_phase;
            r_ck          <= n_ck;
            r_high_nibble <= n_high_nibble;
            r_col_odd     <= n_col_odd;
            r_line_data   <= n_line_data;
            r_acc         <= n_acc;
            r_ck_high     <= n_ck_high;
        end
    end

    a_done_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_DONE) |-> !o_res_push)
        else $error("result produced after finish");

    a_push_needs_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_push |-> (o_tok_pop && !i_res_full))
        else $error("result pushed without consuming a token");

    a_verdict_finishes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_push && (o_result.kind == KIND_OK || o_result.kind == KIND_MISMATCH))
        |=> (r_phase == PH_DONE))
        else $error("checksum verdict did not finish the stream");

endmodule

// ===== design/hex_text_to_binary_checker.sv =====
`timescale 1ns / 1ps

// Hex text to binary checker. Feed one text character per beat (push/full);
// decoded bytes and the final verdict come out in order on a queue-style
// result port (empty/pop). With QUEUE_DEPTH of two or more, a sustained rate of
// one character per clock is held while the result queue has room. Each
// accepted character is registered in the character queue; the back end then
// decodes it, for a data byte updates the running sum (one SUM_WIDTH-bit add
// per data byte), and writes any result into the result queue in the same
// cycle. The back end stalls only while the result queue is full. QUEUE_DEPTH
// sets the depth of both the character queue and the result queue. Once a
// verdict is produced or end of file is seen, later characters are taken and
// dropped until reset.
module hex_text_to_binary_checker
    import htb_pkg::*;
#(
    parameter int SUM_WIDTH   = 32,
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_character,
    input  logic        i_end_of_file,
    output logic        empty,
    input  logic        pop,
    output logic [2:0]  o_kind,
    output logic [7:0]  o_data_byte,
    output logic [15:0] o_computed_sum,
    output logic [15:0] o_received_sum
);

    t_token              tok_in;
    logic [TOKEN_W-1:0]  tok_out;
    logic                tok_empty;
    logic                tok_pop;
    logic                res_full;
    logic                res_push;
    t_result             res_in;
    logic [RESULT_W-1:0] res_out;
    t_result             res_head;

    htb_front u_front (
        .i_character   (i_character),
        .i_end_of_file (i_end_of_file),
        .o_token       (tok_in)
    );

    htb_fifo #(
        .WIDTH (TOKEN_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_tok_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (tok_in),
        .o_full  (full),
        .i_pop   (tok_pop),
        .o_data  (tok_out),
        .o_empty (tok_empty)
    );

    htb_back #(
        .SUM_WIDTH (SUM_WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_token     (t_token'(tok_out)),
        .i_tok_empty (tok_empty),
        .o_tok_pop   (tok_pop),
        .i_res_full  (res_full),
        .o_res_push  (res_push),
        .o_result    (res_in)
    );

    htb_fifo #(
        .WIDTH (RESULT_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res_in),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_data  (res_out),
        .o_empty (empty)
    );

    assign res_head       = t_result'(res_out);
    assign o_kind         = res_head.kind;
    assign o_data_byte    = res_head.data_byte;
    assign o_computed_sum = res_head.computed_sum;
    assign o_received_sum = res_head.received_sum;

endmodule

// ===== test/hex_text_checker_monitor.sv =====
`timescale 1ns / 1ps

module hex_text_checker_monitor
    import htb_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    input  logic        i_full,
    input  logic [7:0]  i_character,
    input  logic        i_end_of_file,
    input  logic        i_empty,
    input  logic        i_pop,
    input  logic [2:0]  i_kind,
    input  logic [7:0]  i_data_byte,
    input  logic [15:0] i_computed_sum,
    input  logic [15:0] i_received_sum,
    output int          o_fail_count,
    output int          o_pending
);

    localparam logic [7:0] LINE_FEED = 8'h0A;

    typedef enum logic [1:0] {WANT_HIGH, WANT_LOW, FINISHED} t_phase;
    typedef enum logic [1:0] {SUM_DATA, SUM_WANT_HIGH, SUM_WANT_LOW} t_sum_mode;

    t_phase     phase = WANT_HIGH;
    t_sum_mode  sum_mode = SUM_DATA;
    logic [3:0] high_nibble = '0;
    logic       column_odd = 1'b0;
    logic       line_has_data = 1'b0;
    logic [31:0] running_sum = '0;
    logic [7:0] check_high_byte = '0;

    t_result expected_results[$];
    int      fail_total = 0;

    assign o_fail_count = fail_total;

    function automatic bit is_hex_char(input logic [7:0] c);
        return (c >= "0" && c <= "9") || (c >= "A" && c <= "F") || (c >= "a" && c <= "f");
    endfunction

    function automatic logic [3:0] nibble_value(input logic [7:0] c);
        logic [7:0] t;
        if (c >= "A" && c <= "F") begin
            t = c - "A" + 8'd10;
        end else if (c >= "a" && c <= "f") begin
            t = c - "a" + 8'd10;
        end else begin
            // anything else wraps into a nibble
            t = c - "0";
        end
        return t[3:0];
    endfunction

    // Advance the decoder by one character; returns 1 when a result follows.
    function automatic bit decode_character(input logic [7:0] c, input logic eof,
                                            output t_result r);
        logic [7:0]  b;
        logic [15:0] folded;
        r = '0;
        if (phase != WANT_HIGH && phase != WANT_LOW) return 1'b0;
        if (eof) begin
            phase = FINISHED;
            if (line_has_data) begin
                r.kind = KIND_MIDLINE;
                return 1'b1;
            end
            if (sum_mode != SUM_WANT_LOW) begin
                r.kind = KIND_NO_CKSUM;
                return 1'b1;
            end
            return 1'b0;
        end
        if (phase == WANT_HIGH) begin
            if (c == LINE_FEED) begin
                if (!line_has_data) sum_mode = SUM_WANT_HIGH;
                column_odd = 1'b0;
                line_has_data = 1'b0;
            end else if (is_hex_char(c)) begin
                high_nibble = nibble_value(c);
                phase = WANT_LOW;
            end
            return 1'b0;
        end
        b = {high_nibble, nibble_value(c)};
        phase = WANT_HIGH;
        if (sum_mode == SUM_WANT_HIGH) begin
            check_high_byte = b;
            sum_mode = SUM_WANT_LOW;
            return 1'b0;
        end
        if (sum_mode == SUM_WANT_LOW) begin
            folded = running_sum[15:0] + running_sum[31:16];
            phase = FINISHED;
            r.kind = (folded == {check_high_byte, b}) ? KIND_OK : KIND_MISMATCH;
            r.computed_sum = folded;
            r.received_sum = {check_high_byte, b};
            return 1'b1;
        end
        running_sum += column_odd ? {24'd0, b} : {16'd0, b, 8'd0};
        column_odd = ~column_odd;
        line_has_data = 1'b1;
        r.kind = KIND_DATA;
        r.data_byte = b;
        return 1'b1;
    endfunction

    function automatic void note_failure(input string what, input t_result want,
                                         input t_result got);
        fail_total++;
        if (fail_total <= 10) begin
            $display("%0t: %s: expected kind %0d byte %h comp %h recv %h,",
                     $realtime, what, want.kind, want.data_byte, want.computed_sum,
                     want.received_sum);
            $display("    got kind %0d byte %h comp %h recv %h",
                     got.kind, got.data_byte, got.computed_sum, got.received_sum);
        end
    endfunction

    always @(posedge i_clk) begin
        t_result predicted;
        t_result observed;
        if (!i_rst_n) begin
            phase = WANT_HIGH;
            sum_mode = SUM_DATA;
            high_nibble = '0;
            column_odd = 1'b0;
            line_has_data = 1'b0;
            running_sum = '0;
            check_high_byte = '0;
            expected_results.delete();
        end else begin
            if (i_push && !i_full) begin
                if (decode_character(i_character, i_end_of_file, predicted))
                    expected_results.push_back(predicted);
            end
            if (i_pop && !i_empty) begin
                observed = {i_kind, i_data_byte, i_computed_sum, i_received_sum};
                if (expected_results.size() == 0) begin
                    note_failure("unexpected beat", '0, observed);
                end else begin
                    predicted = expected_results.pop_front();
                    if (observed !== predicted) note_failure("mismatch", predicted, observed);
                end
            end
        end
        o_pending = expected_results.size();
    end

endmodule

// ===== test/tb_hex_text_to_binary_checker.sv =====
`timescale 1ns / 1ps

module tb_hex_text_to_binary_checker;

    localparam logic [7:0] LINE_FEED = 8'h0A;
    localparam int WATCHDOG_LIMIT = 2000;

    typedef enum logic [2:0] {
        END_GOOD_SUM,
        END_BAD_SUM,
        END_EOF_MIDLINE,
        END_EOF_NO_SUM,
        END_EOF_AFTER_HIGH,
        END_SECOND_BLANK,
        END_EOF_HALF_BYTE,
        END_EOF_AFTER_BLANK
    } t_ending;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic [7:0]  i_character = '0;
    logic        i_end_of_file = 1'b0;
    logic        empty;
    logic        pop = 1'b0;
    logic [2:0]  o_kind;
    logic [7:0]  o_data_byte;
    logic [15:0] o_computed_sum;
    logic [15:0] o_received_sum;

    int fail_count;
    int pending;

    // what the stream sent so far adds up to, for building checksums
    logic [31:0] sent_sum = '0;
    logic        sent_odd = 1'b0;
    int          sent_chars = 0;
    int          burst_left = 0;
    int          stall_mode = 0;
    int          stall_left = 0;
    int          idle_cycles = 0;

    hex_text_to_binary_checker dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_character    (i_character),
        .i_end_of_file  (i_end_of_file),
        .empty          (empty),
        .pop            (pop),
        .o_kind         (o_kind),
        .o_data_byte    (o_data_byte),
        .o_computed_sum (o_computed_sum),
        .o_received_sum (o_received_sum)
    );

    hex_text_checker_monitor monitor (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_push         (push),
        .i_full         (full),
        .i_character    (i_character),
        .i_end_of_file  (i_end_of_file),
        .i_empty        (empty),
        .i_pop          (pop),
        .i_kind         (o_kind),
        .i_data_byte    (o_data_byte),
        .i_computed_sum (o_computed_sum),
        .i_received_sum (o_received_sum),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // receiver: pop under a random stall pattern that is picked anew whenever its run ends
    always @(negedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(20, 80);
        end
        stall_left--;
        case (stall_mode)
            0: pop <= 1'b1;
            1: pop <= 1'($urandom_range(0, 1));
            2: pop <= ($urandom_range(0, 3) == 0);
            default: pop <= ((stall_left % 8) < 4);
        endcase
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((push && !full) || (pop && !empty)) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    function automatic bit is_hex_text(input logic [7:0] c);
        return (c >= "0" && c <= "9") || (c >= "A" && c <= "F") || (c >= "a" && c <= "f");
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] v);
        if (v < 4'd10) return "0" + 8'(v);
        if ($urandom_range(0, 1)) return "a" + 8'(v) - 8'd10;
        return "A" + 8'(v) - 8'd10;
    endfunction

    // a non-hex character that still wraps to nibble v
    function automatic logic [7:0] odd_low_char(input logic [3:0] v);
        logic [7:0] c;
        do begin
            c = 8'd48 + 8'(v) + 8'($urandom_range(0, 15)) * 8'd16;
        end while (is_hex_text(c));
        return c;
    endfunction

    function automatic logic [7:0] noise_char();
        logic [7:0] c;
        do begin
            c = 8'($urandom);
        end while (c == LINE_FEED || is_hex_text(c));
        return c;
    endfunction

    task automatic send_char(input logic [7:0] c, input logic eof);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0) begin
                push <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        push <= 1'b1;
        i_character <= c;
        i_end_of_file <= eof;
        do @(posedge i_clk); while (full);
        @(negedge i_clk);
        burst_left--;
        sent_chars++;
    endtask

    // hold the sender until every outstanding result has been popped
    task automatic drain_results();
        push <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
        burst_left = 0;
    endtask

    task automatic send_pair(input logic [7:0] hi_c, input logic [7:0] lo_c,
                             input logic [7:0] value, input bit counts);
        send_char(hi_c, 1'b0);
        send_char(lo_c, 1'b0);
        if (counts) begin
            sent_sum += sent_odd ? {24'd0, value} : {16'd0, value, 8'd0};
            sent_odd = ~sent_odd;
        end
    endtask

    task automatic send_byte(input logic [7:0] value, input bit counts);
        logic [7:0] lo_c;
        lo_c = ($urandom_range(0, 7) == 0) ? odd_low_char(value[3:0]) : hex_char(value[3:0]);
        send_pair(hex_char(value[7:4]), lo_c, value, counts);
    endtask

    task automatic end_line();
        send_char(LINE_FEED, 1'b0);
        sent_odd = 1'b0;
    endtask

    task automatic send_line(input int n_bytes);
        repeat (n_bytes) begin
            if ($urandom_range(0, 3) == 0) send_char(noise_char(), 1'b0);
            send_byte(8'($urandom), 1'b1);
        end
        if ($urandom_range(0, 3) == 0) send_char(noise_char(), 1'b0);
        end_line();
    endtask

    task automatic send_checksum(input logic [15:0] value);
        send_byte(value[15:8], 1'b0);
        if ($urandom_range(0, 1)) send_char(noise_char(), 1'b0);
        send_byte(value[7:0], 1'b0);
    endtask

    function automatic logic [15:0] folded_sum();
        return sent_sum[15:0] + sent_sum[31:16];
    endfunction

    initial begin
        t_ending ending;
        bit      paused;
        paused = 1'b0;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // extremes, skipped characters, wrapped low nibbles, line feed as low nibble
        send_pair("0", "0", 8'h00, 1'b1);
        send_pair("F", "F", 8'hFF, 1'b1);
        send_pair("a", "B", 8'hAB, 1'b1);
        send_char(" ", 1'b0);
        send_char(8'hFF, 1'b0);
        send_char(8'h00, 1'b0);
        send_pair("9", "f", 8'h9F, 1'b1);
        send_pair("7", LINE_FEED, 8'h7A, 1'b1);
        send_pair("3", "Z", 8'h3A, 1'b1);
        end_line();
        send_pair("C", "0", 8'hC0, 1'b1);
        send_pair("e", 8'h80, 8'hE0, 1'b1);
        end_line();

        while (sent_chars < 520) begin
            if (!paused && sent_chars >= 260) begin
                drain_results();
                paused = 1'b1;
            end else if ($urandom_range(0, 15) == 0) begin
                drain_results();
            end
            send_line($urandom_range(1, 12));
        end

        ending = t_ending'($urandom_range(0, 7));
        case (ending)
            END_GOOD_SUM: begin
                end_line();
                send_checksum(folded_sum());
            end
            END_BAD_SUM: begin
                end_line();
                send_checksum(folded_sum() ^ 16'($urandom_range(1, 65535)));
            end
            END_EOF_MIDLINE: begin
                send_byte(8'($urandom), 1'b1);
                send_char(8'($urandom), 1'b1);
            end
            END_EOF_NO_SUM: begin
                send_char(8'($urandom), 1'b1);
            end
            END_EOF_AFTER_HIGH: begin
                end_line();
                send_byte(8'($urandom), 1'b0);
                send_char(8'($urandom), 1'b1);
            end
            END_SECOND_BLANK: begin
                // a blank line after the high byte restarts the checksum
                end_line();
                send_byte(8'($urandom), 1'b0);
                end_line();
                if ($urandom_range(0, 1)) send_checksum(folded_sum());
                else send_checksum(16'($urandom));
            end
            END_EOF_HALF_BYTE: begin
                if ($urandom_range(0, 1)) send_byte(8'($urandom), 1'b1);
                send_char(hex_char(4'($urandom)), 1'b0);
                send_char(8'($urandom), 1'b1);
            end
            default: begin
                end_line();
                send_char(8'($urandom), 1'b1);
            end
        endcase

        // everything after the end is dropped
        repeat (16) send_char(8'($urandom), 1'($urandom_range(0, 1)));

        push <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
        repeat (20) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
